### hw/rtl/lcdsr_pkg.sv
package lcdsr_pkg;

   // Request codes carried on req_cmd.
   typedef enum logic [2:0] {
      CMD_DATA            = 3'd0,
      CMD_INSTRUCTION     = 3'd1,
      CMD_CHAR_AT         = 3'd2,
      CMD_NUMBER_AT       = 3'd3,
      CMD_DISPLAY_OPTIONS = 3'd4,
      CMD_SPARE_5         = 3'd5,
      CMD_SPARE_6         = 3'd6,
      CMD_SPARE_7         = 3'd7
   } lcd_cmd_type;

   // Control register indexes.
   localparam logic [1:0] REG_BACKLIGHT = 2'd0;
   localparam logic [1:0] REG_LED       = 2'd1;

   // One LCD bus byte waiting to be split into nibble beats.
   typedef struct packed {
      logic [7:0] data;
      logic       rs;
      logic       last;
   } lcd_entry_type;

   // Control bits of the shift byte.
   localparam int BIT_RS = 0;
   localparam int BIT_EN = 1;
   localparam int BIT_BL = 2;
   localparam int BIT_LD = 3;

endpackage

### hw/rtl/lcdsr_front.sv
module lcdsr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   input  logic [16:0]           req_value,
   input  logic                  req_row,
   input  logic [5:0]            req_col,
   output logic                  push,
   output lcdsr_pkg::lcd_entry_type push_entry,
   input  logic                  queue_full
);
   import lcdsr_pkg::*;

   localparam logic [16:0] NUM_MAX   = 17'd99999;
   localparam logic [7:0]  BASE_TOP  = 8'h80;
   localparam logic [7:0]  BASE_BOT  = 8'hC0;
   localparam logic [7:0]  CHAR_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_BLANK = 8'h20;
   localparam logic [7:0]  OPT_BASE  = 8'h08;
   localparam logic [2:0]  STEP_UNITS = 3'd5;

   // Takes one decimal digit of the given weight off the number: {digit, remainder}.
   function automatic logic [20:0] take_digit(input logic [16:0] num,
                                              input logic [16:0] weight);
      logic [3:0]  d;
      logic [16:0] r;
      d = '0;
      r = num;
      for (int k = 1; k < 10; k++) begin
         if ({4'd0, num} >= 21'(k) * {4'd0, weight}) begin
            d = 4'(k);
            r = num - 17'(21'(k) * {4'd0, weight});
         end
      end
      return {d, r};
   endfunction

   logic          busy_ff, busy_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [2:0]    step_ff, step_in;
   logic [7:0]    char_ff, char_in;
   logic [7:0]    pos_ff, pos_in;
   logic [16:0]   num_ff, num_in;
   logic          seen_ff, seen_in;

   logic          accept;
   logic [20:0]   split;
   logic [3:0]    digit;
   logic [16:0]   remain;
   logic          seen_now;
   lcd_entry_type entry;

   // Digit extraction for the current step of a number request.
   always_comb begin
      unique case (step_ff)
         3'd1:    split = take_digit(num_ff, 17'd10000);
         3'd2:    split = take_digit(num_ff, 17'd1000);
         3'd3:    split = take_digit(num_ff, 17'd100);
         3'd4:    split = take_digit(num_ff, 17'd10);
         default: split = {num_ff[3:0], 17'd0};
      endcase
      digit    = split[20:17];
      remain   = split[16:0];
      seen_now = seen_ff || (digit != 4'd0) || (step_ff == STEP_UNITS);
   end

   // LCD byte produced by the current step.
   always_comb begin
      entry = '0;
      unique case (cmd_ff)
         CMD_DATA: begin
            entry.data = char_ff;
            entry.rs   = 1'b1;
            entry.last = 1'b1;
         end
         CMD_INSTRUCTION: begin
            entry.data = char_ff;
            entry.last = 1'b1;
         end
         CMD_CHAR_AT: begin
            entry.data = (step_ff == 3'd0) ? pos_ff : char_ff;
            entry.rs   = (step_ff != 3'd0);
            entry.last = (step_ff != 3'd0);
         end
         CMD_NUMBER_AT: begin
            if (step_ff == 3'd0) begin
               entry.data = pos_ff;
            end else begin
               entry.data = seen_now ? (CHAR_ZERO | {4'd0, digit}) : CHAR_BLANK;
               entry.rs   = 1'b1;
               entry.last = (step_ff == STEP_UNITS);
            end
         end
         CMD_DISPLAY_OPTIONS: begin
            entry.data = OPT_BASE | {5'd0, char_ff[2:0]};
            entry.last = 1'b1;
         end
         default: entry = '0;
      endcase
   end

   assign push       = busy_ff && !queue_full;
   assign push_entry = entry;
   assign req_ready  = !busy_ff || (push && entry.last);
   assign accept     = req_valid && req_ready;

   // Next state: a new request overrides the finishing one.
   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      step_in = step_ff;
      char_in = char_ff;
      pos_in  = pos_ff;
      num_in  = num_ff;
      seen_in = seen_ff;
      if (push) begin
         step_in = step_ff + 3'd1;
         if (entry.last) begin
            busy_in = 1'b0;
         end
         if (step_ff != 3'd0) begin
            num_in  = remain;
            seen_in = seen_now;
         end
      end
      if (accept) begin
         busy_in = (req_cmd <= CMD_DISPLAY_OPTIONS);
         cmd_in  = req_cmd;
         step_in = 3'd0;
         char_in = req_value[7:0];
         pos_in  = (req_row ? BASE_BOT : BASE_TOP) | {2'd0, req_col};
         num_in  = (req_value > NUM_MAX) ? NUM_MAX : req_value;
         seen_in = 1'b0;
      end
   end

   // Request holding registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
         seen_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         seen_ff <= seen_in;
      end
      cmd_ff  <= cmd_in;
      char_ff <= char_in;
      pos_ff  <= pos_in;
      num_ff  <= num_in;
   end

endmodule

### hw/rtl/lcdsr_fifo.sv
module lcdsr_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  lcdsr_pkg::lcd_entry_type wr_data,
   output logic                     full,
   input  logic                     rd_en,
   output logic                     rd_valid,
   output lcdsr_pkg::lcd_entry_type rd_data
);
   import lcdsr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lcd_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### hw/rtl/lcdsr_back.sv
module lcdsr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     backlight_on,
   input  logic                     led_on,
   input  logic                     q_valid,
   input  lcdsr_pkg::lcd_entry_type q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_shift_byte,
   output logic                     rsp_last
);
   import lcdsr_pkg::*;

   localparam logic [1:0] PHASE_LAST = 2'd3;

   lcd_entry_type cur_ff;
   logic          cur_valid_ff;
   logic [1:0]    phase_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_shift_byte_ff, shift_byte_in;
   logic          rsp_last_ff;
   logic          out_take, cur_done;
   logic [3:0]    nibble;

   assign out_take = !rsp_valid_ff || rsp_ready;
   assign cur_done = cur_valid_ff && out_take && (phase_ff == PHASE_LAST);
   assign q_pop    = q_valid && (!cur_valid_ff || cur_done);

   // Phase 0/1 carry the high nibble, 2/3 the low one; enable is set on even phases.
   always_comb begin
      nibble        = phase_ff[1] ? cur_ff.data[3:0] : cur_ff.data[7:4];
      shift_byte_in = {nibble, 4'd0};
      shift_byte_in[BIT_RS] = cur_ff.rs;
      shift_byte_in[BIT_EN] = !phase_ff[0];
      shift_byte_in[BIT_BL] = backlight_on;
      shift_byte_in[BIT_LD] = led_on;
   end

   // Current LCD byte and phase counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= 2'd0;
      end else begin
         if (cur_valid_ff && out_take) begin
            phase_ff <= phase_ff + 2'd1;
         end
         if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            phase_ff     <= 2'd0;
         end
      end
      if (q_pop) begin
         cur_ff <= q_data;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= cur_valid_ff;
      end
      if (out_take && cur_valid_ff) begin
         rsp_shift_byte_ff <= shift_byte_in;
         rsp_last_ff       <= cur_ff.last && (phase_ff == PHASE_LAST);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_shift_byte = rsp_shift_byte_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### hw/rtl/char_lcd_shift_register_writer.sv
// Character LCD writer for a 4-bit bus behind a serial-in parallel-out register.
// Request channel (req_*): cmd selects data char, instruction, char at position,
// number at position or display options; value, row and col carry the operands.
// Each LCD byte leaves on the rsp_* channel as four shift-byte beats: high nibble
// with EN set, then cleared, then the low nibble the same way. rsp_last marks the
// final beat of a request. Unused command codes give no beats.
// Control channel (csr_*): index 0 is backlight, index 1 the LED; other indexes
// are ignored. Writes are always taken and should happen while the block is idle.
// A request is held in the front-end registers; its LCD bytes pass the queue, the
// current-byte register and the output register. Throughput: one beat per cycle
// while rsp_ready is high; a request gives 4, 8 or 24 beats for one, two or six
// LCD bytes; the serializer sets the rate. The front end splits a number request
// one decimal digit per cycle while the queue has room, ahead of the serializer.
// The front end takes the next request while the queue and output register still
// drain, so requests follow each other without gaps. When the receiver stalls,
// the output register holds its beat, the queue fills and req_ready drops.
// Reset clears both control registers, the queue and all valid flags.
module char_lcd_shift_register_writer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [16:0] req_value,
   input  logic        req_row,
   input  logic [5:0]  req_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_shift_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata
);
   import lcdsr_pkg::*;

   logic          backlight_ff, led_ff;
   logic          push, queue_full, q_valid, q_pop;
   lcd_entry_type push_entry, q_data;

   assign csr_ready = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b0;
         led_ff       <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == REG_BACKLIGHT) begin
            backlight_ff <= csr_wdata;
         end
         if (csr_index == REG_LED) begin
            led_ff <= csr_wdata;
         end
      end
   end

   // Request decoding into LCD bytes.
   lcdsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .req_row    (req_row),
      .req_col    (req_col),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Queue of pending LCD bytes.
   lcdsr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (push_entry),
      .full     (queue_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // Nibble beat serializer and output register.
   lcdsr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .backlight_on   (backlight_ff),
      .led_on         (led_ff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_last       (rsp_last)
   );

endmodule

### test/char_lcd_shift_register_writer_test.sv
`timescale 1ns / 1ps

module char_lcd_shift_register_writer_test;
   import lcdsr_pkg::*;

   // Control register indexes with no register behind them.
   localparam logic [1:0] REG_SPARE_2   = 2'd2;
   localparam logic [1:0] REG_SPARE_3   = 2'd3;

   localparam logic [7:0]  TOP_LINE_BASE    = 8'h80;
   localparam logic [7:0]  BOTTOM_LINE_BASE = 8'hC0;
   localparam logic [7:0]  DIGIT_BASE       = 8'h30;
   localparam logic [7:0]  BLANK_CHAR       = 8'h20;
   localparam logic [7:0]  DISPLAY_CONTROL  = 8'h08;
   localparam int unsigned NUMBER_MAX       = 99999;

   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [7:0] shift_byte;
      logic       last;
   } shift_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = 3'd0;
   logic [16:0] req_value = 17'd0;
   logic        req_row = 1'b0;
   logic [5:0]  req_col = 6'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_shift_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic        csr_wdata = 1'b0;

   // Predictor copy of the control registers.
   logic backlight_setting = 1'b0;
   logic led_setting = 1'b0;

   shift_beat_type request_beats[$];
   shift_beat_type pending_beats[$];
   shift_beat_type oldest_beat;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int requests_accepted = 0;
   int number_requests = 0;
   int beats_checked = 0;
   int cycle_count = 0;

   char_lcd_shift_register_writer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats still expected", $time, pending_beats.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver drops ready at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // One nibble becomes two beats: enable set, then cleared.
   function automatic void stage_nibble(input logic [3:0] nibble, input logic rs);
      logic [7:0] bus;
      bus = {nibble, 4'b0000};
      bus[BIT_RS] = rs;
      bus[BIT_BL] = backlight_setting;
      bus[BIT_LD] = led_setting;
      bus[BIT_EN] = 1'b1;
      request_beats.push_back('{shift_byte: bus, last: 1'b0});
      bus[BIT_EN] = 1'b0;
      request_beats.push_back('{shift_byte: bus, last: 1'b0});
   endfunction

   function automatic void stage_lcd_byte(input logic [7:0] lcd_byte, input logic rs);
      stage_nibble(lcd_byte[7:4], rs);
      stage_nibble(lcd_byte[3:0], rs);
   endfunction

   // Works out the beats that one accepted request must produce.
   function automatic void expand_request(input logic [2:0] cmd, input logic [16:0] value,
                                          input logic row, input logic [5:0] col);
      logic [7:0]  position;
      int unsigned number;
      int unsigned divisor;
      int unsigned digit;
      logic        shown;
      request_beats.delete();
      position = (row ? BOTTOM_LINE_BASE : TOP_LINE_BASE) | {2'b00, col};
      case (cmd)
         CMD_DATA: stage_lcd_byte(value[7:0], 1'b1);
         CMD_INSTRUCTION: stage_lcd_byte(value[7:0], 1'b0);
         CMD_CHAR_AT: begin
            stage_lcd_byte(position, 1'b0);
            stage_lcd_byte(value[7:0], 1'b1);
         end
         CMD_NUMBER_AT: begin
            number = (value > NUMBER_MAX) ? NUMBER_MAX : value;
            divisor = 10000;
            shown = 1'b0;
            stage_lcd_byte(position, 1'b0);
            // Leading zeros show as blanks; the units digit always shows.
            for (int place = 0; place < 5; place++) begin
               digit = (number / divisor) % 10;
               shown = shown || (digit != 0) || (place == 4);
               stage_lcd_byte(shown ? DIGIT_BASE + 8'(digit) : BLANK_CHAR, 1'b1);
               divisor = divisor / 10;
            end
         end
         CMD_DISPLAY_OPTIONS: stage_lcd_byte(DISPLAY_CONTROL | {5'b00000, value[2:0]}, 1'b0);
         default: ;
      endcase
      if (request_beats.size() != 0) begin
         request_beats[request_beats.size() - 1].last = 1'b1;
      end
      foreach (request_beats[i]) begin
         pending_beats.push_back(request_beats[i]);
      end
   endfunction

   // Accepted requests and register writes update the prediction.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expand_request(req_cmd, req_value, req_row, req_col);
         requests_accepted++;
         if (req_cmd == CMD_NUMBER_AT) begin
            number_requests++;
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_BACKLIGHT: backlight_setting = csr_wdata;
            REG_LED: led_setting = csr_wdata;
            default: ;
         endcase
      end
   end

   // Every accepted beat is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat: expected none, got shift_byte %02h last %0b",
                     $time, rsp_shift_byte, rsp_last);
         end else begin
            oldest_beat = pending_beats.pop_front();
            beats_checked++;
            if (oldest_beat.shift_byte !== rsp_shift_byte) begin
               mismatch_count++;
               $display("%0t: shift_byte mismatch: expected %02h, got %02h",
                        $time, oldest_beat.shift_byte, rsp_shift_byte);
            end
            if (oldest_beat.last !== rsp_last) begin
               mismatch_count++;
               $display("%0t: last mismatch: expected %0b, got %0b",
                        $time, oldest_beat.last, rsp_last);
            end
         end
      end
   end

   // Presents one request and holds it until accepted. Valid stays high into
   // the next request unless an idle gap comes first.
   task automatic send_request(input lcd_cmd_type cmd, input logic [16:0] value,
                               input logic row, input logic [5:0] col);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      req_row   <= row;
      req_col   <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops sending and waits until all expected beats have arrived and the
   // pipeline has had time to empty behind requests that produce nothing.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random request biased toward numbers and positioned characters.
   task automatic send_random_request;
      int          pick;
      lcd_cmd_type cmd;
      logic [16:0] value;
      logic [5:0]  col;
      pick = $urandom_range(99);
      if (pick < 12) cmd = CMD_DATA;
      else if (pick < 22) cmd = CMD_INSTRUCTION;
      else if (pick < 40) cmd = CMD_CHAR_AT;
      else if (pick < 70) cmd = CMD_NUMBER_AT;
      else if (pick < 88) cmd = CMD_DISPLAY_OPTIONS;
      else cmd = lcd_cmd_type'($urandom_range(5, 7));
      pick = $urandom_range(99);
      if (cmd == CMD_NUMBER_AT && pick < 40) value = 17'($urandom_range(0, 999));
      else if (cmd == CMD_NUMBER_AT && pick < 70) value = 17'($urandom_range(0, 99999));
      else value = 17'($urandom);
      col = ($urandom_range(3) != 0) ? 6'($urandom_range(0, 39)) : 6'($urandom);
      send_request(cmd, value, 1'($urandom), col);
   endtask

   task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                   input logic backlight, input logic led, input int count);
      drain();
      write_register(REG_BACKLIGHT, backlight);
      write_register(REG_LED, led);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      repeat (count) send_random_request();
      drain();
   endtask

   // Field extremes, every request code and the corner cases, reset settings.
   task automatic test_directed;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_request(CMD_DATA, 17'h00000, 1'b0, 6'd0);
      send_request(CMD_DATA, 17'h1FFFF, 1'b1, 6'd63);
      send_request(CMD_INSTRUCTION, 17'h00001, 1'b0, 6'd0);
      send_request(CMD_INSTRUCTION, 17'h1FF00, 1'b1, 6'd39);
      send_request(CMD_CHAR_AT, 17'h00041, 1'b0, 6'd0);
      send_request(CMD_CHAR_AT, 17'h1FF7E, 1'b1, 6'd63);
      send_request(CMD_CHAR_AT, 17'h0005A, 1'b0, 6'd39);
      send_request(CMD_SPARE_5, 17'h1FFFF, 1'b1, 6'd63);
      send_request(CMD_NUMBER_AT, 17'd0, 1'b0, 6'd0);
      send_request(CMD_NUMBER_AT, 17'd5, 1'b1, 6'd10);
      send_request(CMD_NUMBER_AT, 17'd40, 1'b0, 6'd20);
      send_request(CMD_NUMBER_AT, 17'd10005, 1'b1, 6'd1);
      send_request(CMD_SPARE_6, 17'h00000, 1'b0, 6'd0);
      send_request(CMD_NUMBER_AT, 17'd99999, 1'b0, 6'd35);
      // Values past the five-digit range saturate.
      send_request(CMD_NUMBER_AT, 17'd100000, 1'b1, 6'd39);
      send_request(CMD_NUMBER_AT, 17'h1FFFF, 1'b0, 6'd63);
      send_request(CMD_DISPLAY_OPTIONS, 17'h00000, 1'b0, 6'd0);
      send_request(CMD_DISPLAY_OPTIONS, 17'h00007, 1'b1, 6'd0);
      send_request(CMD_DISPLAY_OPTIONS, 17'h1FFF8, 1'b0, 6'd63);
      send_request(CMD_SPARE_7, 17'h15555, 1'b1, 6'd42);
      drain();
   endtask

   task automatic test_backlight_no_idle;
      run_random_phase(0, 0, 1'b1, 1'b0, 110);
   endtask

   task automatic test_led_sender_idle;
      run_random_phase(81, 0, 1'b0, 1'b1, 110);
   endtask

   task automatic test_both_bits_receiver_stall;
      run_random_phase(0, 81, 1'b1, 1'b1, 110);
   endtask

   // Writes to unused indexes must leave both control bits cleared.
   task automatic test_spare_registers_both_idle;
      drain();
      write_register(REG_BACKLIGHT, 1'b0);
      write_register(REG_LED, 1'b0);
      write_register(REG_SPARE_2, 1'b1);
      write_register(REG_SPARE_3, 1'b1);
      sender_idle_pct = 37;
      receiver_stall_pct = 37;
      repeat (100) send_random_request();
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backlight_no_idle();
      test_led_sender_idle();
      test_both_bits_receiver_stall();
      test_spare_registers_both_idle();
      $display("Sent %0d requests (%0d numbers) and checked %0d shift beats", requests_accepted,
               number_requests, beats_checked);
      $display("under all four backlight and LED settings and four idle and stall mixes.");
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
